// ===== hw/rtl/hlfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlfd_pkg;

    // Frame layout: header, one byte, length, payload, footer
    localparam int unsigned OVERHEAD_BYTES = 5;
    localparam int unsigned LENGTH_POS     = 2;

    localparam logic [7:0] HEADER_RESET = 8'hA5;
    localparam logic [7:0] FOOTER_RESET = 8'h5A;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_FOOTER = 2'd1,
        STATUS_TOO_LONG   = 2'd2,
        STATUS_OVERFLOW   = 2'd3
    } status_t;

    typedef enum logic {
        REG_HEADER = 1'b0,
        REG_FOOTER = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLLECT,
        ST_READ,
        ST_SHOW,
        ST_ERROR
    } hlfd_state_t;

    typedef struct packed {
        logic    store;
        logic    clear;
        logic    err_load;
        status_t err_code;
        logic    drain_start;
        logic    drain_read;
        logic    drain_adv;
        logic    show_err;
    } hlfd_cmd_t;

    typedef struct packed {
        logic header_match;
        logic full;
        logic len_pos;
        logic len_too_big;
        logic frame_done;
        logic footer_ok;
        logic drain_last;
    } hlfd_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hlfd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfd_dp
    import hlfd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] header_byte,
    input  wire logic [7:0] footer_byte,
    input  wire hlfd_cmd_t  cmd,
    output hlfd_stat_t      stat,
    output logic [7:0]      out_byte,
    output logic [5:0]      byte_index,
    output logic            last,
    output logic [1:0]      status
);

    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    logic [7:0]    mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] expected_reg;
    logic [CW-1:0] expected_next;
    logic [AW-1:0] drain_idx_reg;
    logic [AW-1:0] drain_idx_next;
    status_t       err_code_reg;
    logic [8:0]    total_len;

    assign total_len = 9'(rx_byte) + 9'(OVERHEAD_BYTES);

    always_comb
    begin
        stat.header_match = (rx_byte == header_byte);
        stat.full         = (fill_reg == CW'(BUFFER_DEPTH));
        stat.len_pos      = (fill_reg == CW'(LENGTH_POS));
        stat.len_too_big  = (total_len > 9'(BUFFER_DEPTH));
        stat.frame_done   = (expected_reg != '0) && (fill_reg + CW'(1) == expected_reg);
        stat.footer_ok    = (rx_byte == footer_byte);
        stat.drain_last   = (CW'(drain_idx_reg) + CW'(1) == fill_reg);
    end

    always_comb
    begin
        fill_next      = fill_reg;
        expected_next  = expected_reg;
        drain_idx_next = drain_idx_reg;
        if (cmd.store)
        begin
            fill_next = fill_reg + CW'(1);
            if (fill_reg == CW'(LENGTH_POS))
            begin
                expected_next = CW'(total_len);
            end
        end
        if (cmd.clear)
        begin
            fill_next     = '0;
            expected_next = '0;
        end
        if (cmd.drain_start)
        begin
            drain_idx_next = '0;
        end
        else if (cmd.drain_adv)
        begin
            drain_idx_next = drain_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            expected_reg  <= '0;
            drain_idx_reg <= '0;
            err_code_reg  <= STATUS_OK;
        end
        else
        begin
            fill_reg      <= fill_next;
            expected_reg  <= expected_next;
            drain_idx_reg <= drain_idx_next;
            if (cmd.err_load)
            begin
                err_code_reg <= cmd.err_code;
            end
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[fill_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.drain_read)
        begin
            rd_data_reg <= mem[drain_idx_reg];
        end
    end

    always_comb
    begin
        if (cmd.show_err)
        begin
            out_byte   = '0;
            byte_index = '0;
            last       = 1'b1;
            status     = err_code_reg;
        end
        else
        begin
            out_byte   = rd_data_reg;
            byte_index = 6'(drain_idx_reg);
            last       = stat.drain_last;
            status     = STATUS_OK;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(BUFFER_DEPTH))
        else $error("fill count beyond store depth");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (fill_reg < CW'(BUFFER_DEPTH)))
        else $error("store issued into a full buffer");

endmodule

`default_nettype wire

// ===== hw/rtl/hlfd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlfd_ctrl
    import hlfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire hlfd_stat_t stat,
    output hlfd_cmd_t       cmd
);

    hlfd_state_t state_reg;
    hlfd_state_t state_next;
    logic        in_take;

    assign in_take = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && stat.header_match)
                begin
                    state_next = ST_COLLECT;
                end
            end
            ST_COLLECT:
            begin
                if (in_take)
                begin
                    priority if (stat.full)
                    begin
                        state_next = ST_ERROR;
                    end
                    else if (stat.len_pos && stat.len_too_big)
                    begin
                        state_next = ST_ERROR;
                    end
                    else if (stat.frame_done)
                    begin
                        state_next = stat.footer_ok ? ST_READ : ST_ERROR;
                    end
                    else
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = stat.drain_last ? ST_IDLE : ST_READ;
                end
            end
            ST_ERROR:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.store = in_valid && stat.header_match;
            end
            ST_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    priority if (stat.full)
                    begin
                        cmd.clear    = 1'b1;
                        cmd.err_load = 1'b1;
                        cmd.err_code = STATUS_OVERFLOW;
                    end
                    else if (stat.len_pos && stat.len_too_big)
                    begin
                        cmd.store    = 1'b1;
                        cmd.clear    = 1'b1;
                        cmd.err_load = 1'b1;
                        cmd.err_code = STATUS_TOO_LONG;
                    end
                    else if (stat.frame_done && !stat.footer_ok)
                    begin
                        cmd.store    = 1'b1;
                        cmd.clear    = 1'b1;
                        cmd.err_load = 1'b1;
                        cmd.err_code = STATUS_BAD_FOOTER;
                    end
                    else
                    begin
                        cmd.store       = 1'b1;
                        cmd.drain_start = stat.frame_done;
                    end
                end
            end
            ST_READ:
            begin
                cmd.drain_read = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.clear     = stat.drain_last;
                    cmd.drain_adv = !stat.drain_last;
                end
            end
            ST_ERROR:
            begin
                out_valid    = 1'b1;
                cmd.show_err = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is presented");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHOW && !out_stall && stat.drain_last) |=> state_reg == ST_IDLE)
        else $error("drain did not return to idle after last byte");

    a_err_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ERROR && !out_stall) |=> state_reg == ST_IDLE)
        else $error("error result not retired");

endmodule

`default_nettype wire

// ===== hw/rtl/header_length_footer_deframer.sv =====
// Header/length/footer deframer.
// Input channel: one received byte per request (in_valid, in_stall, rx_byte).
// Bytes are dropped while idle until one matches the header register; that byte
// and the ones after it are stored. The third stored byte is the payload
// length; the frame totals that value plus 5 bytes.
// Output channel (out_valid, out_stall): a good frame is replayed one request
// per byte with byte_index and last on the final byte; a bad footer, a length
// beyond the store, or a full store gives a single request with status set.
// Throughput: one input byte per cycle while collecting. Once a frame is in,
// in_stall stays high until every result is taken. Each frame byte goes
// through two states: a registered read of the frame store, then a state
// presenting it, which holds until the byte is taken.
// A stalled result holds its payload until out_stall drops.
// Reset: header 0xA5, footer 0x5A, block idle. The store is not cleared;
// only entries written in the current frame are ever read.
// APB: header at 0x0, footer at 0x4; pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module header_length_footer_deframer
    import hlfd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic [5:0]       byte_index,
    output logic             last,
    output logic [1:0]       status,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] header_reg;
    logic [7:0] footer_reg;
    cfg_reg_t   cfg_sel;
    logic       cfg_write;
    hlfd_cmd_t  cmd;
    hlfd_stat_t stat;

    // Register index is the word address; byte offset bits are ignored
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_FOOTER: footer_reg <= pwdata[7:0];
                default:    header_reg <= header_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_HEADER: prdata = {24'd0, header_reg};
            REG_FOOTER: prdata = {24'd0, footer_reg};
            default:    prdata = '0;
        endcase
    end

    // Sequencer: decides store, error and drain steps
    hlfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Frame store, counters and result payload
    hlfd_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .header_byte (header_reg),
        .footer_byte (footer_reg),
        .cmd         (cmd),
        .stat        (stat),
        .out_byte    (out_byte),
        .byte_index  (byte_index),
        .last        (last),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== sim/header_length_footer_deframer_tb.sv =====
`timescale 1ns / 1ps

module header_length_footer_deframer_tb;
    import hlfd_pkg::*;

    localparam int unsigned BUFFER_DEPTH   = 64;
    // Good frames show their first byte after the READ state that follows
    // the footer byte; give the block a little more than that.
    localparam int unsigned SETTLE_CYCLES  = 6;
    // Cycles without any accepted request before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_LEN        = BUFFER_DEPTH - OVERHEAD_BYTES;

    typedef struct {
        logic [7:0] out_byte;
        logic [5:0] byte_index;
        logic       last;
        status_t    status;
    } frame_result_t;

    // Shadow of the deframer: its own copy of the registers and frame store,
    // plus the queue of results the block still owes.
    class frame_scoreboard;
        logic [7:0]    header;
        logic [7:0]    footer;
        logic [7:0]    store [BUFFER_DEPTH];
        int unsigned   fill;
        int unsigned   total;
        frame_result_t owed_q [$];
        int unsigned   errors;
        int unsigned   results_seen;
        int unsigned   frames_good;
        int unsigned   frames_rejected;

        function new();
            header          = HEADER_RESET;
            footer          = FOOTER_RESET;
            fill            = 0;
            total           = 0;
            errors          = 0;
            results_seen    = 0;
            frames_good     = 0;
            frames_rejected = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [7:0] v);
            if (r == REG_HEADER)
                header = v;
            else
                footer = v;
        endfunction

        function void push_result(logic [7:0] b, logic [5:0] idx, logic l, status_t st);
            frame_result_t r;
            r.out_byte   = b;
            r.byte_index = idx;
            r.last       = l;
            r.status     = st;
            owed_q.push_back(r);
        endfunction

        function void reject(status_t st);
            fill  = 0;
            total = 0;
            frames_rejected++;
            push_result(8'h00, 6'd0, 1'b1, st);
        endfunction

        // Note one accepted input byte and queue whatever it causes.
        function void note_byte(logic [7:0] b);
            int unsigned span;
            if (fill == 0) begin
                if (b == header) begin
                    store[0] = b;
                    fill     = 1;
                    total    = 0;
                end
                return;
            end
            if (fill < BUFFER_DEPTH) begin
                store[fill] = b;
                fill++;
            end else begin
                reject(STATUS_OVERFLOW);
                return;
            end
            if (fill == LENGTH_POS + 1) begin
                span = OVERHEAD_BYTES + int'(store[LENGTH_POS]);
                if (span > BUFFER_DEPTH) begin
                    reject(STATUS_TOO_LONG);
                    return;
                end
                total = span;
            end
            if (total > 0 && fill == total) begin
                if (store[fill - 1] != footer) begin
                    reject(STATUS_BAD_FOOTER);
                    return;
                end
                for (int i = 0; i < fill; i++)
                    push_result(store[i], 6'(i), (i + 1 == fill), STATUS_OK);
                frames_good++;
                fill  = 0;
                total = 0;
            end
        endfunction

        // Compare one accepted result with the oldest one owed.
        function void check_result(logic [7:0] ob, logic [5:0] bi, logic l, logic [1:0] st);
            frame_result_t want;
            results_seen++;
            if (owed_q.size() == 0) begin
                $error("unexpected result: out_byte 0x%02h byte_index %0d last %0d status %0d",
                       ob, bi, l, st);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (ob !== want.out_byte) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, ob);
                errors++;
            end
            if (bi !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, bi);
                errors++;
            end
            if (l !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, l);
                errors++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [1:0]  status;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    bit              steady      = 1'b0;  // no idling on either side while set
    int unsigned     bytes_sent  = 0;
    int unsigned     frame_bytes = 0;     // bytes sent as part of frames
    int unsigned     settings    = 1;
    int unsigned     quiet       = 0;

    header_length_footer_deframer #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_index (byte_index),
        .last       (last),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: take a request whenever out_valid is up and we are not
    // stalling, and pick the stall for the next cycle at random.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(out_byte, byte_index, last, status);
            out_stall <= !steady && ($urandom_range(0, 99) < 15);
        end
    end

    // Watchdog: count cycles in which no request moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the block takes it. Valid is only
    // dropped for an idle gap, so back-to-back bytes keep it high.
    task automatic send_byte(logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Line noise between frames; steer clear of the header so frames stay aligned.
    task automatic send_noise(int unsigned n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == sb.header)
                b = ~b;
            send_byte(b);
        end
    endtask

    // One frame: header, one free byte, length, len+1 payload bytes, footer.
    // A length beyond the store stops after the length byte.
    task automatic send_frame(int unsigned len, bit good_end);
        logic [7:0] tail;
        send_byte(sb.header);
        send_byte(8'($urandom));
        send_byte(8'(len));
        frame_bytes += 3;
        if (len > MAX_LEN)
            return;
        repeat (len + 1) send_byte(8'($urandom));
        tail = good_end ? sb.footer : sb.footer ^ 8'($urandom_range(1, 255));
        send_byte(tail);
        frame_bytes += len + 2;
    endtask

    // Close out any frame left open by broken sequences: feed footer bytes
    // until the block drops back to idle, either by a good frame or an error.
    task automatic settle_frame();
        while (sb.fill != 0)
            send_byte(sb.footer);
    endtask

    // Drop valid, wait for every owed result, then let the block settle.
    task automatic quiesce();
        in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a back-to-back read of the same register.
    task automatic set_register(cfg_reg_t r, logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {24'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(r, v);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {24'h0, v}) begin
            $error("prdata: expected 0x%08h, got 0x%08h", {24'h0, v}, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic new_setting(logic [7:0] hdr, logic [7:0] ftr);
        set_register(REG_HEADER, hdr);
        set_register(REG_FOOTER, ftr);
        settings++;
    endtask

    // Random traffic: mostly well-formed frames of random content, with some
    // noise, truncated frames, oversize lengths and bad footers mixed in.
    task automatic run_phase(int unsigned budget);
        int unsigned start_count;
        int unsigned pick;
        int unsigned len;
        start_count = frame_bytes;
        while (frame_bytes - start_count < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_noise($urandom_range(1, 4));
            end else if (pick < 14) begin
                // truncated frame: the next header lands inside it
                send_byte(sb.header);
                frame_bytes++;
                repeat ($urandom_range(0, 1)) send_byte(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(0, 8);
                else if (pick < 86)
                    len = $urandom_range(9, 40);
                else if (pick < 92)
                    len = $urandom_range(41, MAX_LEN);
                else
                    len = $urandom_range(MAX_LEN + 1, 255);
                send_frame(len, $urandom_range(0, 99) < 85);
            end
        end
        settle_frame();
        quiesce();
    endtask

    initial
    begin
        // Opening sequence under the reset header/footer: dropped noise at
        // the byte extremes, the shortest good frame, two oversize lengths,
        // a bad footer, and a frame whose inner bytes hold header and footer.
        logic [7:0] opening [$] = '{
            8'h00, 8'hFF, FOOTER_RESET,
            HEADER_RESET, 8'h00, 8'h00, 8'hFF, FOOTER_RESET,
            HEADER_RESET, 8'h12, 8'd60,
            HEADER_RESET, 8'h34, 8'hFF,
            HEADER_RESET, 8'h01, 8'h00, 8'h77, FOOTER_RESET ^ 8'h01,
            HEADER_RESET, FOOTER_RESET, 8'h01, HEADER_RESET, 8'hFF, FOOTER_RESET
        };

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);
        quiesce();

        // Reset setting: one frame at the full store size, then random traffic.
        send_frame(MAX_LEN, 1'b1);
        run_phase(55);

        // Low/high extremes, with both sides running flat out.
        steady = 1'b1;
        new_setting(8'h00, 8'hFF);
        run_phase(50);
        steady = 1'b0;

        new_setting(8'hFF, 8'h00);
        run_phase(50);

        new_setting(8'($urandom), 8'($urandom));
        run_phase(45);

        // Back to the reset values; finish with another full-size frame.
        new_setting(HEADER_RESET, FOOTER_RESET);
        run_phase(45);
        send_frame(MAX_LEN, 1'b1);
        quiesce();

        $display("covered %0d input bytes and %0d results over %0d header/footer settings",
                 bytes_sent, sb.results_seen, settings);
        $display("frames: %0d delivered, %0d rejected", sb.frames_good, sb.frames_rejected);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
